### rtl/core/lfuc_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache package
// Shared types and operation codes for the LFU cache with pinning.
// ----------------------------------------------------------------------------
package lfuc_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned ValW   = 32;
  localparam int unsigned StampW = 64;
  localparam int unsigned LimW   = 7;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_PROBE  = 2'd2,
    OP_PROBE3 = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic            dirty;
  } req_t;

  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] value_out;
    logic            evict_valid;
    logic [KeyW-1:0] evict_key;
    logic [ValW-1:0] evict_value;
    logic            dropped;
  } rsp_t;

endpackage

### rtl/core/lfuc_req_if.sv
// ----------------------------------------------------------------------------
// LFU cache request channel
// Valid/ready channel carrying one cache request.
// ----------------------------------------------------------------------------
interface lfuc_req_if;
  logic             valid;
  logic             ready;
  lfuc_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/lfuc_rsp_if.sv
// ----------------------------------------------------------------------------
// LFU cache response channel
// Valid/ready channel carrying one cache response.
// ----------------------------------------------------------------------------
interface lfuc_rsp_if;
  logic             valid;
  logic             ready;
  lfuc_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/lfuc_cfg_if.sv
// ----------------------------------------------------------------------------
// LFU cache configuration channel
// Valid/ready write channel for the capacity limit register.
// ----------------------------------------------------------------------------
interface lfuc_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/lfuc_ram.sv
// ----------------------------------------------------------------------------
// LFU cache RAM
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lfuc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### rtl/core/lfu_cache_with_pinning_core.sv
// ----------------------------------------------------------------------------
// LFU cache with pinning, top level
// Fully associative cache with bounded LFU replacement and pinning.
// ----------------------------------------------------------------------------
// Each request is scanned, decided, written back and answered before the next
// one is accepted. The scan reads every entry out of the entry RAM, one per
// cycle (valid, pinned, key, handle, dirty, use count, stamp), to find the key
// match, the resident count, the lowest free slot and the eviction victim. A
// decide state then fixes the response, a write state writes back at most one
// entry, and the response is then offered in the response state; a stalled
// response holds off the next request. After reset a clearing pass marks every
// entry invalid before the first request is taken. One request is in flight at
// a time.
module lfu_cache_with_pinning_core #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned USE_LEVELS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  lfuc_req_if.sink   req,
  lfuc_rsp_if.source rsp,
  lfuc_cfg_if.sink   cfg
);
  import lfuc_pkg::*;

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned UW   = $clog2(USE_LEVELS);
  localparam int unsigned EW   = 2 + KeyW + ValW + 1 + UW + StampW;
  localparam int unsigned LW   = (CW > LimW) ? CW : LimW;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DECIDE, ST_WRITE, ST_RESP
  } state_e;

  typedef struct packed {
    logic              valid;
    logic              pinned;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   handle;
    logic              dirty;
    logic [UW-1:0]     use_cnt;
    logic [StampW-1:0] stamp;
  } entry_t;

  state_e state_q;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic [LimW-1:0] limit_q;
  logic [StampW-1:0] stamp_q;

  logic [CW-1:0] idx_q;
  logic          rd_pend_q;
  logic [AW-1:0] rd_addr_q;
  logic          match_q, free_found_q, victim_found_q;
  logic [AW-1:0] match_idx_q, free_idx_q, victim_idx_q;
  entry_t        match_e_q, victim_e_q;
  logic [CW-1:0] count_q;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  entry_t        ram_wdata, ram_rdata;
  logic [EW-1:0] ram_rd_raw;

  logic [LW-1:0] lim_eff;
  logic          full;
  logic          use_max;

  assign ram_rdata = entry_t'(ram_rd_raw);

  lfuc_ram #(.Width(EW), .Depth(CAPACITY)) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(EW'(ram_wdata)),
    .rdata_o(ram_rd_raw)
  );

  always_comb begin
    if (limit_q == '0) begin
      lim_eff = LW'(1);
    end else if (LW'(limit_q) > LW'(CAPACITY)) begin
      lim_eff = LW'(CAPACITY);
    end else begin
      lim_eff = LW'(limit_q);
    end
  end

  assign full    = LW'(count_q) >= lim_eff;
  assign use_max = (32'(match_e_q.use_cnt) + 32'd1) >= USE_LEVELS;

  // Response for the scanned request.
  always_comb begin
    rsp_d     = '0;
    rsp_d.hit = match_q;
    if (req_q.operation == OP_LOOKUP && match_q) begin
      rsp_d.value_out = match_e_q.handle;
    end
    if (req_q.operation == OP_INSERT && !match_q && full) begin
      if (!victim_found_q) begin
        rsp_d.dropped = 1'b1;
      end else if (victim_e_q.dirty) begin
        rsp_d.evict_valid = 1'b1;
        rsp_d.evict_key   = victim_e_q.key;
        rsp_d.evict_value = victim_e_q.handle;
      end
    end
  end

  // Entry write for the clearing pass and the decided action.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_q[AW-1:0];
    ram_wdata = match_e_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_WRITE: begin
        if (match_q) begin
          ram_addr = match_idx_q;
          if (req_q.operation == OP_INSERT) begin
            ram_we           = 1'b1;
            ram_wdata.handle = req_q.value;
            ram_wdata.dirty  = req_q.dirty;
          end else if (req_q.operation == OP_LOOKUP && !match_e_q.pinned) begin
            ram_we = 1'b1;
            if (use_max) begin
              ram_wdata.pinned = 1'b1;
            end else begin
              ram_wdata.use_cnt = match_e_q.use_cnt + UW'(1);
              ram_wdata.stamp   = stamp_q;
            end
          end
        end else if (req_q.operation == OP_INSERT && !rsp_q.dropped) begin
          // Evicted slot is reused; otherwise take the lowest free slot.
          ram_we            = 1'b1;
          ram_addr          = (full || !free_found_q) ? victim_idx_q : free_idx_q;
          ram_wdata.valid   = 1'b1;
          ram_wdata.pinned  = 1'b0;
          ram_wdata.key     = req_q.key;
          ram_wdata.handle  = req_q.value;
          ram_wdata.dirty   = req_q.dirty;
          ram_wdata.use_cnt = '0;
          ram_wdata.stamp   = stamp_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign req.ready = (state_q == ST_IDLE);
  assign rsp.valid = (state_q == ST_RESP);
  assign rsp.data  = rsp_q;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      req_q          <= '0;
      rsp_q          <= '0;
      limit_q        <= LimW'(64);
      stamp_q        <= '0;
      idx_q          <= '0;
      rd_pend_q      <= 1'b0;
      rd_addr_q      <= '0;
      match_q        <= 1'b0;
      free_found_q   <= 1'b0;
      victim_found_q <= 1'b0;
      match_idx_q    <= '0;
      free_idx_q     <= '0;
      victim_idx_q   <= '0;
      match_e_q      <= '0;
      victim_e_q     <= '0;
      count_q        <= '0;
    end else begin
      if (cfg.valid) begin
        limit_q <= cfg.data;
      end
      case (state_q)
        ST_CLEAR: begin
          idx_q <= idx_q + CW'(1);
          if (idx_q == CW'(CAPACITY - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            req_q          <= req.data;
            idx_q          <= '0;
            rd_pend_q      <= 1'b0;
            match_q        <= 1'b0;
            free_found_q   <= 1'b0;
            victim_found_q <= 1'b0;
            count_q        <= '0;
            state_q        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue read of entry idx_q, evaluate the entry read last cycle.
          if (idx_q < CW'(CAPACITY)) begin
            idx_q     <= idx_q + CW'(1);
            rd_addr_q <= idx_q[AW-1:0];
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
          end
          if (rd_pend_q && !ram_rdata.valid && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= rd_addr_q;
          end
          if (rd_pend_q && ram_rdata.valid) begin
            count_q <= count_q + CW'(1);
            if (ram_rdata.key == req_q.key) begin
              match_q     <= 1'b1;
              match_idx_q <= rd_addr_q;
              match_e_q   <= ram_rdata;
            end
            if (!ram_rdata.pinned && (!victim_found_q ||
                ram_rdata.use_cnt < victim_e_q.use_cnt ||
                (ram_rdata.use_cnt == victim_e_q.use_cnt &&
                 ram_rdata.stamp < victim_e_q.stamp))) begin
              victim_found_q <= 1'b1;
              victim_idx_q   <= rd_addr_q;
              victim_e_q     <= ram_rdata;
            end
          end
          if (!rd_pend_q && idx_q == CW'(CAPACITY)) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          rsp_q   <= rsp_d;
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (match_q) begin
            if (req_q.operation == OP_LOOKUP && !match_e_q.pinned && !use_max) begin
              stamp_q <= stamp_q + StampW'(1);
            end
          end else if (req_q.operation == OP_INSERT && !rsp_q.dropped) begin
            stamp_q <= stamp_q + StampW'(1);
          end
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (rsp.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Pinned entries are always resident.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && rd_pend_q) |-> !(ram_rdata.pinned && !ram_rdata.valid))
    else $error("pinned slot not valid");

  // A dropped insert never evicts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !(rsp_q.dropped && rsp_q.evict_valid))
    else $error("dropped and evicted together");

  // Residency never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DECIDE |-> count_q <= CW'(CAPACITY))
    else $error("resident count overflow");
endmodule
